// ----- src/legv8_subset_execute_assert.svh -----
// Assertion macros for the execute block RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef LEGV8_SUBSET_EXECUTE_ASSERT_SVH
`define LEGV8_SUBSET_EXECUTE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/lse_pkg.sv -----
// Shared types and constants for the LEGv8-subset execute block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lse_pkg;

	localparam int NUM_REGS    = 11;
	localparam int RIDX_W      = $clog2(NUM_REGS);
	localparam int DW_W        = 8;
	localparam int DATA_WORDS  = 1 << DW_W;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int IMM_W       = 19;

	localparam logic [31:0] RESET_START = 32'd200;
	localparam logic [31:0] STEP_BYTES  = 32'd4;
	localparam logic [4:0]  REG_LIMIT   = 5'(NUM_REGS);

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_ADDI = 3'd1,
		OP_LDUR = 3'd2,
		OP_STUR = 3'd3,
		OP_B    = 3'd4,
		OP_SUB  = 3'd5,
		OP_CBZ  = 3'd6
	} op_t;

	// Classified instruction handed from the front end to the back end.
	typedef struct packed {
		op_t                     op;
		logic                    bad;
		logic                    rd_a;
		logic                    rd_b;
		logic [3:0]              idx_a;
		logic [3:0]              idx_b;
		logic [3:0]              rt;
		logic signed [IMM_W-1:0] imm;
	} uop_t;

	function automatic logic idx_bad(input logic [3:0] idx);
		return {1'b0, idx} >= REG_LIMIT;
	endfunction

endpackage

// ----- src/legv8_subset_execute.sv -----
// LEGv8-subset execute block, top level: wires front end, queue and back end.
// Depends on lse_pkg, lse_front, lse_queue and lse_back.
//
// Usage:
//   Input channel in_valid/in_ready carries one decoded instruction word
//   (opcode, target_reg, first_reg, second_reg, immediate). Output channel
//   out_valid/out_ready carries one result word per instruction, in order.
//   cfg_we/cfg_wdata writes the start address and loads the PC at once;
//   write only while the block is idle.
//   Path: an accepted word is registered in the queue slot, then in the
//   read/execute stage, then in the result register that drives out_valid.
//   Throughput: one word per cycle while the receiver takes results; a word that
//   reads the register a load directly ahead of it writes is held back, as the
//   registered data store read feeds the register bypass.
//   Reset: PC = 200, registers and data store read as zero, queue empty.
//   A stalled receiver holds the result register; the two-entry queue keeps
//   taking words until it fills, then in_ready drops.
`timescale 1ns / 1ps

module legv8_subset_execute import lse_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [31:0]             cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              opcode,
	input  logic [3:0]              target_reg,
	input  logic [3:0]              first_reg,
	input  logic [3:0]              second_reg,
	input  logic signed [IMM_W-1:0] immediate,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [31:0]             next_pc,
	output logic                    reg_written,
	output logic [3:0]              written_index,
	output logic signed [31:0]      written_value,
	output logic                    mem_written,
	output logic                    branch_taken,
	output logic                    bad_index
);

	uop_t uop;
	uop_t head;
	logic push;
	logic q_full;
	logic head_valid;
	logic pop;

	lse_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.target_reg (target_reg),
		.first_reg  (first_reg),
		.second_reg (second_reg),
		.immediate  (immediate),
		.q_full     (q_full),
		.push       (push),
		.uop        (uop)
	);

	lse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.din        (uop),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	lse_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.next_pc       (next_pc),
		.reg_written   (reg_written),
		.written_index (written_index),
		.written_value (written_value),
		.mem_written   (mem_written),
		.branch_taken  (branch_taken),
		.bad_index     (bad_index)
	);

endmodule

// ----- src/lse_front.sv -----
// Front end: takes input words and classifies them (index check, operand ports).
// Depends on lse_pkg.
`timescale 1ns / 1ps

module lse_front import lse_pkg::*; (
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              opcode,
	input  logic [3:0]              target_reg,
	input  logic [3:0]              first_reg,
	input  logic [3:0]              second_reg,
	input  logic signed [IMM_W-1:0] immediate,
	input  logic                    q_full,
	output logic                    push,
	output uop_t                    uop
);

	op_t  op;
	logic bad;

	assign op       = op_t'(opcode);
	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		case (op)
			OP_ADD, OP_SUB: begin
				bad = idx_bad(target_reg) || idx_bad(first_reg) || idx_bad(second_reg);
			end
			OP_ADDI, OP_LDUR, OP_STUR: begin
				bad = idx_bad(target_reg) || idx_bad(first_reg);
			end
			OP_CBZ: begin
				bad = idx_bad(target_reg);
			end
			default: begin
				bad = 1'b0;
			end
		endcase
	end

	always_comb begin
		uop.op    = op;
		uop.bad   = bad;
		uop.rd_a  = !bad && (op inside {OP_ADD, OP_ADDI, OP_LDUR, OP_STUR, OP_SUB});
		uop.rd_b  = !bad && (op inside {OP_ADD, OP_SUB, OP_STUR, OP_CBZ});
		uop.idx_a = first_reg;
		// port B carries the second source for ALU ops, else the target register
		uop.idx_b = (op inside {OP_ADD, OP_SUB}) ? second_reg : target_reg;
		uop.rt    = target_reg;
		uop.imm   = immediate;
	end

endmodule

// ----- src/lse_queue.sv -----
// Short queue of classified instructions between front and back ends.
// Depends on lse_pkg.
`timescale 1ns / 1ps

module lse_queue import lse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  uop_t din,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output uop_t head
);

	uop_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= din;
		end
	end

endmodule

// ----- src/lse_back.sv -----
// Back end: register read with bypass, execute/memory stage, result register.
// Depends on lse_pkg and legv8_subset_execute_assert.svh.
`timescale 1ns / 1ps
`include "legv8_subset_execute_assert.svh"

module lse_back import lse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	input  logic               head_valid,
	input  uop_t               head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        next_pc,
	output logic               reg_written,
	output logic [3:0]         written_index,
	output logic signed [31:0] written_value,
	output logic               mem_written,
	output logic               branch_taken,
	output logic               bad_index
);

	// register file and data store with per-entry valid bits
	logic [31:0]           rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0]   rf_vld_q;
	logic [31:0]           dm_mem [DATA_WORDS];
	logic [DATA_WORDS-1:0] dm_vld_q;
	logic [31:0]           dm_rdata_q;
	logic                  dm_rvld_q;

	logic [31:0] pc_q;

	// read/execute stage
	logic        valid_s2;
	uop_t        uop_s2;
	logic [31:0] opa_s2;
	logic [31:0] opb_s2;

	// result stage
	logic        valid_s3;
	logic [31:0] npc_s3;
	logic        regw_s3;
	logic [3:0]  widx_s3;
	logic [31:0] val_s3;
	logic        ld_s3;
	logic        memw_s3;
	logic        taken_s3;
	logic        bad_s3;

	logic              adv;
	logic              hazard;
	logic              issue;
	logic [31:0]       imm32;
	logic [31:0]       sum_imm;
	logic [31:0]       alu_c;
	logic              aligned;
	logic              alu_w_c;
	logic              ld_c;
	logic              st_c;
	logic              taken_c;
	logic [31:0]       npc_c;
	logic [DW_W-1:0]   waddr;
	logic [31:0]       wval_out;
	logic              rf_wr;
	logic              fwd2_a;
	logic              fwd2_b;
	logic              fwd3_a;
	logic              fwd3_b;
	logic [RIDX_W-1:0] ra;
	logic [RIDX_W-1:0] rb;

	assign adv = !valid_s3 || out_ready;

	// hold the head while it needs a load result still in flight
	assign hazard = valid_s2 && (uop_s2.op == OP_LDUR) && !uop_s2.bad &&
		((head.rd_a && head.idx_a == uop_s2.rt) || (head.rd_b && head.idx_b == uop_s2.rt));
	assign issue  = adv && head_valid && !hazard;
	assign pop    = issue;

	assign imm32   = {{(32 - IMM_W){uop_s2.imm[IMM_W-1]}}, uop_s2.imm};
	assign sum_imm = opa_s2 + imm32;
	assign aligned = sum_imm[1:0] == 2'b00;
	assign waddr   = sum_imm[DW_W+1:2];

	always_comb begin
		case (uop_s2.op)
			OP_ADD:  alu_c = opa_s2 + opb_s2;
			OP_SUB:  alu_c = opa_s2 - opb_s2;
			default: alu_c = sum_imm;
		endcase
	end

	always_comb begin
		alu_w_c = 1'b0;
		ld_c    = 1'b0;
		st_c    = 1'b0;
		taken_c = 1'b0;
		if (!uop_s2.bad) begin
			case (uop_s2.op)
				OP_ADD, OP_ADDI, OP_SUB: alu_w_c = 1'b1;
				OP_LDUR:                 ld_c    = aligned;
				OP_STUR:                 st_c    = aligned;
				OP_B:                    taken_c = 1'b1;
				OP_CBZ:                  taken_c = opb_s2 == '0;
				default:                 ;
			endcase
		end
		npc_c = taken_c ? (pc_q + {imm32[29:0], 2'b00}) : (pc_q + STEP_BYTES);
	end

	assign wval_out = ld_s3 ? (dm_rvld_q ? dm_rdata_q : '0) : val_s3;
	assign rf_wr    = valid_s3 && out_ready && regw_s3;

	// bypass: the executing ALU op first, then the pending result
	assign fwd2_a = valid_s2 && alu_w_c && (uop_s2.rt == head.idx_a);
	assign fwd2_b = valid_s2 && alu_w_c && (uop_s2.rt == head.idx_b);
	assign fwd3_a = valid_s3 && regw_s3 && (widx_s3 == head.idx_a);
	assign fwd3_b = valid_s3 && regw_s3 && (widx_s3 == head.idx_b);
	assign ra     = head.idx_a[RIDX_W-1:0];
	assign rb     = head.idx_b[RIDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			pc_q     <= RESET_START;
			rf_vld_q <= '0;
			dm_vld_q <= '0;
		end else begin
			if (adv) begin
				valid_s3 <= valid_s2;
				valid_s2 <= issue;
			end
			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end else if (adv && valid_s2) begin
				pc_q <= npc_c;
			end
			if (rf_wr) begin
				rf_vld_q[widx_s3[RIDX_W-1:0]] <= 1'b1;
			end
			if (adv && valid_s2 && st_c) begin
				dm_vld_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			uop_s2 <= head;
			if (fwd2_a) begin
				opa_s2 <= alu_c;
			end else if (fwd3_a) begin
				opa_s2 <= wval_out;
			end else begin
				opa_s2 <= rf_vld_q[ra] ? rf_mem[ra] : '0;
			end
			if (fwd2_b) begin
				opb_s2 <= alu_c;
			end else if (fwd3_b) begin
				opb_s2 <= wval_out;
			end else begin
				opb_s2 <= rf_vld_q[rb] ? rf_mem[rb] : '0;
			end
		end
		if (adv) begin
			npc_s3     <= npc_c;
			regw_s3    <= alu_w_c || ld_c;
			widx_s3    <= (alu_w_c || ld_c) ? uop_s2.rt : '0;
			val_s3     <= alu_w_c ? alu_c : (st_c ? opb_s2 : '0);
			ld_s3      <= ld_c;
			memw_s3    <= st_c;
			taken_s3   <= taken_c;
			bad_s3     <= uop_s2.bad;
			dm_rdata_q <= dm_mem[waddr];
			dm_rvld_q  <= dm_vld_q[waddr];
		end
		if (adv && valid_s2 && st_c) begin
			dm_mem[waddr] <= opb_s2;
		end
		if (rf_wr) begin
			rf_mem[widx_s3[RIDX_W-1:0]] <= wval_out;
		end
	end

	assign out_valid     = valid_s3;
	assign next_pc       = npc_s3;
	assign reg_written   = regw_s3;
	assign written_index = widx_s3;
	assign written_value = $signed(wval_out);
	assign mem_written   = memw_s3;
	assign branch_taken  = taken_s3;
	assign bad_index     = bad_s3;

	`LSE_ASSERT_IMP(a_one_effect, clk, arst_n, valid_s3, !(regw_s3 && memw_s3), "reg and mem write together")
	`LSE_ASSERT_IMP(a_bad_quiet, clk, arst_n, valid_s3 && bad_s3, !regw_s3 && !memw_s3 && !taken_s3, "bad index had an effect")
	`LSE_ASSERT_IMP(a_widx_range, clk, arst_n, valid_s3 && regw_s3, !idx_bad(widx_s3), "write index out of range")
	`LSE_ASSERT_NXT(a_stall_drains, clk, arst_n, hazard && adv, valid_s3 && !valid_s2, "load-use stall left no bubble")

endmodule
